@@ rtl/core/fca_pkg.sv @@
// Types and constants shared by the allocator core and its extent memory.
`timescale 1ns / 1ps
`default_nettype none
package fca_pkg;

  localparam int unsigned GRAN_SHIFT = 4;
  localparam int unsigned START_W = 20;
  localparam int unsigned LEN_W = 21;
  localparam int unsigned NEED_W = 22;
  localparam logic [LEN_W-1:0] POOL_GRAN_MAX = LEN_W'(1 << START_W);

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOFIT = 3'd1;
  localparam logic [2:0] ST_NOTPOOL = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO = 3'd4;

  localparam logic [1:0] CFG_POOL_BASE = 2'd0;
  localparam logic [1:0] CFG_POOL_BYTES = 2'd1;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } extent_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_FINAL,
    S_RESP
  } state_e;

endpackage
`default_nettype wire

@@ rtl/core/first_fit_coalescing_allocator_core.sv @@
// First-fit allocator core: address-ordered free-extent table with coalescing.
//
//   channel | signals                                        | direction
//   cfg     | cfg_valid_i cfg_ready_o cfg_index_i cfg_data_i | in
//   req     | in_valid_i in_ready_o operation_i req_size_i block_address_i | in
//   rsp     | out_valid_o out_ready_i result_address_o status_o | out
//
// One word at a time: a scan up to the chosen extent (one memory read per cycle),
// then, where entries must shift, one entry move per cycle over the extents after it.
// After reset or a write to the pool base or pool size, S_INIT writes the initial extent.
// The response register frees the core while a result waits.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_coalescing_allocator_core #(
  parameter int unsigned MAX_EXTENTS = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        operation_i,
  input  wire logic [24:0] req_size_i,
  input  wire logic [31:0] block_address_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      result_address_o,
  output logic [2:0]       status_o
);

  localparam int unsigned AW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = $clog2(MAX_EXTENTS + 1);
  localparam int unsigned SW = fca_pkg::START_W;
  localparam int unsigned LW = fca_pkg::LEN_W;
  localparam int unsigned NW = fca_pkg::NEED_W;
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  fca_pkg::state_e state_q, state_d;
  logic [31:0] base_q, base_d;
  logic [24:0] pbytes_q, pbytes_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic op_q, op_d;
  logic [NW-1:0] need_q, need_d;
  logic [SW-1:0] bs_q, bs_d;
  logic [CW-1:0] sc_q, sc_d;
  logic dv_q, dv_d;
  logic [AW-1:0] dk_q, dk_d;
  logic [CW-1:0] i_q, i_d;
  fca_pkg::extent_t prev_q, prev_d, nx_q, nx_d, fw_q, fw_d;
  logic prev_v_q, prev_v_d, nx_v_q, nx_v_d, fw_en_q, fw_en_d;
  logic [AW-1:0] fw_a_q, fw_a_d;
  logic [AW-1:0] mv_src_q, mv_src_d, mv_wa_q, mv_wa_d;
  logic [CW-1:0] mv_left_q, mv_left_d;
  logic mv_up_q, mv_up_d, mv_pend_q, mv_pend_d;
  logic [31:0] res_addr_q, res_addr_d;
  logic [2:0] res_st_q, res_st_d;
  logic ov_q, ov_d;
  logic [31:0] oaddr_q, oaddr_d;
  logic [2:0] ost_q, ost_d;

  logic we;
  logic [AW-1:0] waddr, raddr;
  fca_pkg::extent_t wdata, rdata;

  logic [25:0] pb_sum;
  logic [21:0] pg_raw;
  logic [LW-1:0] pg;
  logic [25:0] sz_sum;
  logic [NW-1:0] need_in;
  logic [31:0] off;
  logic [28:0] be_in;
  logic hit;
  logic [NW-1:0] prev_end, be;
  logic jp, jn;

  fca_extent_ram #(.DEPTH(MAX_EXTENTS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign pb_sum = {1'b0, pbytes_q} + 26'd15;
  assign pg_raw = pb_sum[25:4];
  always_comb begin
    if (pg_raw == '0) begin
      pg = LW'(1);
    end else if (pg_raw > NW'(fca_pkg::POOL_GRAN_MAX)) begin
      pg = fca_pkg::POOL_GRAN_MAX;
    end else begin
      pg = pg_raw[LW-1:0];
    end
  end

  assign sz_sum = {1'b0, req_size_i} + 26'd15;
  assign need_in = sz_sum[25:4];
  assign off = block_address_i - base_q;
  assign be_in = {1'b0, off[31:4]} + 29'(need_in);

  assign prev_end = NW'(prev_q.start) + NW'(prev_q.len);
  assign be = NW'(bs_q) + need_q;
  assign jp = prev_v_q && (prev_end == NW'(bs_q));
  assign jn = nx_v_q && (be == NW'(nx_q.start));

  assign hit = dv_q && ((op_q == fca_pkg::OP_ALLOC) ? (NW'(rdata.len) >= need_q)
                                                     : (rdata.start > bs_q));

  assign cfg_ready_o = 1'b1;
  assign in_ready_o = (state_q == fca_pkg::S_IDLE);
  assign out_valid_o = ov_q;
  assign result_address_o = oaddr_q;
  assign status_o = ost_q;

  always_comb begin
    state_d = state_q;
    base_d = base_q;
    pbytes_d = pbytes_q;
    cnt_d = cnt_q;
    op_d = op_q;
    need_d = need_q;
    bs_d = bs_q;
    sc_d = sc_q;
    dv_d = 1'b0;
    dk_d = sc_q[AW-1:0];
    i_d = i_q;
    prev_d = prev_q;
    prev_v_d = prev_v_q;
    nx_d = nx_q;
    nx_v_d = nx_v_q;
    fw_d = fw_q;
    fw_en_d = fw_en_q;
    fw_a_d = fw_a_q;
    mv_src_d = mv_src_q;
    mv_wa_d = mv_wa_q;
    mv_left_d = mv_left_q;
    mv_up_d = mv_up_q;
    mv_pend_d = 1'b0;
    res_addr_d = res_addr_q;
    res_st_d = res_st_q;
    ov_d = ov_q;
    oaddr_d = oaddr_q;
    ost_d = ost_q;
    we = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = sc_q[AW-1:0];

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      fca_pkg::S_INIT: begin
        we = 1'b1;
        waddr = '0;
        wdata.start = '0;
        wdata.len = pg;
        cnt_d = CW'(1);
        state_d = fca_pkg::S_IDLE;
      end
      fca_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d = operation_i;
          need_d = need_in;
          bs_d = off[SW+3:4];
          res_addr_d = '0;
          res_st_d = fca_pkg::ST_OK;
          sc_d = '0;
          prev_v_d = 1'b0;
          nx_v_d = 1'b0;
          fw_en_d = 1'b0;
          if (req_size_i == '0) begin
            res_st_d = fca_pkg::ST_ZERO;
            state_d = fca_pkg::S_RESP;
          end else if (operation_i == fca_pkg::OP_FREE &&
                       ({1'b0, off[31:4]} >= 29'(pg) || be_in > 29'(pg))) begin
            res_st_d = fca_pkg::ST_NOTPOOL;
            state_d = fca_pkg::S_RESP;
          end else begin
            state_d = fca_pkg::S_SCAN;
          end
        end
      end
      fca_pkg::S_SCAN: begin
        raddr = sc_q[AW-1:0];
        if (hit) begin
          i_d = CW'(dk_q);
          nx_d = rdata;
          nx_v_d = 1'b1;
          state_d = fca_pkg::S_DECIDE;
        end else begin
          if (dv_q) begin
            prev_d = rdata;
            prev_v_d = 1'b1;
          end
          if (sc_q < cnt_q) begin
            dv_d = 1'b1;
            sc_d = sc_q + CW'(1);
          end else begin
            i_d = cnt_q;
            nx_v_d = 1'b0;
            state_d = fca_pkg::S_DECIDE;
          end
        end
      end
      fca_pkg::S_DECIDE: begin
        state_d = fca_pkg::S_RESP;
        mv_up_d = 1'b1;
        mv_src_d = AW'(i_q + CW'(1));
        mv_left_d = cnt_q - i_q - CW'(1);
        if (op_q == fca_pkg::OP_ALLOC) begin
          if (!nx_v_q) begin
            res_st_d = fca_pkg::ST_NOFIT;
          end else begin
            res_addr_d = base_q + {8'd0, nx_q.start, 4'd0};
            if (NW'(nx_q.len) == need_q) begin
              cnt_d = cnt_q - CW'(1);
              state_d = fca_pkg::S_MOVE;
            end else begin
              we = 1'b1;
              waddr = i_q[AW-1:0];
              wdata.start = nx_q.start + need_q[SW-1:0];
              wdata.len = nx_q.len - need_q[LW-1:0];
            end
          end
        end else begin
          if ((prev_v_q && prev_end > NW'(bs_q)) ||
              (nx_v_q && be > NW'(nx_q.start))) begin
            res_st_d = fca_pkg::ST_NOTPOOL;
          end else if (jp) begin
            we = 1'b1;
            waddr = AW'(i_q - CW'(1));
            wdata.start = prev_q.start;
            if (jn) begin
              wdata.len = prev_q.len + need_q[LW-1:0] + nx_q.len;
              cnt_d = cnt_q - CW'(1);
              state_d = fca_pkg::S_MOVE;
            end else begin
              wdata.len = prev_q.len + need_q[LW-1:0];
            end
          end else if (jn) begin
            we = 1'b1;
            waddr = i_q[AW-1:0];
            wdata.start = bs_q;
            wdata.len = nx_q.len + need_q[LW-1:0];
          end else if (cnt_q >= CNT_MAX) begin
            res_st_d = fca_pkg::ST_FULL;
          end else begin
            mv_up_d = 1'b0;
            mv_src_d = AW'(cnt_q - CW'(1));
            mv_left_d = cnt_q - i_q;
            fw_en_d = 1'b1;
            fw_a_d = i_q[AW-1:0];
            fw_d.start = bs_q;
            fw_d.len = need_q[LW-1:0];
            cnt_d = cnt_q + CW'(1);
            state_d = fca_pkg::S_MOVE;
          end
        end
      end
      fca_pkg::S_MOVE: begin
        raddr = mv_src_q;
        if (mv_pend_q) begin
          we = 1'b1;
          waddr = mv_wa_q;
          wdata = rdata;
        end
        if (mv_left_q != '0) begin
          mv_pend_d = 1'b1;
          mv_wa_d = mv_up_q ? (mv_src_q - AW'(1)) : (mv_src_q + AW'(1));
          mv_src_d = mv_up_q ? (mv_src_q + AW'(1)) : (mv_src_q - AW'(1));
          mv_left_d = mv_left_q - CW'(1);
        end else if (!mv_pend_q) begin
          state_d = fca_pkg::S_FINAL;
        end
      end
      fca_pkg::S_FINAL: begin
        if (fw_en_q) begin
          we = 1'b1;
          waddr = fw_a_q;
          wdata = fw_q;
        end
        state_d = fca_pkg::S_RESP;
      end
      fca_pkg::S_RESP: begin
        if (!ov_q || out_ready_i) begin
          ov_d = 1'b1;
          oaddr_d = res_addr_q;
          ost_d = res_st_q;
          state_d = fca_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fca_pkg::S_INIT;
      end
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == fca_pkg::CFG_POOL_BASE) begin
        base_d = cfg_data_i;
        state_d = fca_pkg::S_INIT;
      end else if (cfg_index_i == fca_pkg::CFG_POOL_BYTES) begin
        pbytes_d = cfg_data_i[24:0];
        state_d = fca_pkg::S_INIT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fca_pkg::S_INIT;
      base_q <= '0;
      pbytes_q <= 25'd1048576;
      cnt_q <= CW'(1);
      dv_q <= 1'b0;
      mv_pend_q <= 1'b0;
      mv_left_q <= '0;
      ov_q <= 1'b0;
      fw_en_q <= 1'b0;
      prev_v_q <= 1'b0;
      nx_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      base_q <= base_d;
      pbytes_q <= pbytes_d;
      cnt_q <= cnt_d;
      dv_q <= dv_d;
      mv_pend_q <= mv_pend_d;
      mv_left_q <= mv_left_d;
      ov_q <= ov_d;
      fw_en_q <= fw_en_d;
      prev_v_q <= prev_v_d;
      nx_v_q <= nx_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q <= op_d;
    need_q <= need_d;
    bs_q <= bs_d;
    sc_q <= sc_d;
    dk_q <= dk_d;
    i_q <= i_d;
    prev_q <= prev_d;
    nx_q <= nx_d;
    fw_q <= fw_d;
    fw_a_q <= fw_a_d;
    mv_src_q <= mv_src_d;
    mv_wa_q <= mv_wa_d;
    mv_up_q <= mv_up_d;
    res_addr_q <= res_addr_d;
    res_st_q <= res_st_d;
    oaddr_q <= oaddr_d;
    ost_q <= ost_d;
  end

endmodule
`default_nettype wire

@@ rtl/core/fca_extent_ram.sv @@
// Extent table memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none
module fca_extent_ram #(
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire fca_pkg::extent_t wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output fca_pkg::extent_t      rdata_o
);

  fca_pkg::extent_t mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire
